[design/mi3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types, widths and helpers of the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TOL_W         = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam int COF_W  = 2 * ELEM_W + 1;   // signed cofactor
  localparam int CMAG_W = 2 * ELEM_W;       // cofactor magnitude
  localparam int DS_W   = 3 * ELEM_W + 4;   // signed determinant sum
  localparam int MAG_W  = 3 * ELEM_W;       // determinant magnitude

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'({1'b0, {(ELEM_W-1){1'b1}}});
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'({1'b1, {(ELEM_W-1){1'b0}}});

  // operand indexes of each cofactor a*b - c*d, in inverse element order
  localparam int COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 8, 1}, '{1, 5, 4, 2},
    '{5, 6, 8, 3}, '{0, 8, 2, 6}, '{2, 3, 5, 0},
    '{3, 7, 6, 4}, '{1, 6, 7, 0}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic signed [ELEM_W-1:0] determinant;
    logic                     invertible;
    logic                     saturated;
  } mi3_out_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] val;
    logic                     sat;
  } mi3_clip_t;

  typedef struct packed {
    mi3_clip_t det;
    logic      inv;
  } mi3_side_t;

  // Clip a sign and magnitude to the element range.
  function automatic mi3_clip_t mi3_clip(input logic [MAG_W-1:0] mag, input logic neg,
                                         input logic ovf);
    mi3_clip_t r;
    if (!neg) begin
      if (ovf || (mag > POS_LIM)) begin
        r.val = {1'b0, {(ELEM_W-1){1'b1}}};
        r.sat = 1'b1;
      end else begin
        r.val = mag[ELEM_W-1:0];
        r.sat = 1'b0;
      end
    end else begin
      if (ovf || (mag > NEG_LIM)) begin
        r.val = {1'b1, {(ELEM_W-1){1'b0}}};
        r.sat = 1'b1;
      end else begin
        r.val = -mag[ELEM_W-1:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[design/mi3_cof.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof
// Two stages: pair products, then the nine adjugate cofactors.
// ----------------------------------------------------------------------------
module mi3_cof (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [mi3_pkg::ELEM_W-1:0] e_in   [9],
  output logic signed [mi3_pkg::COF_W-1:0]  cof    [9],
  output logic signed [mi3_pkg::ELEM_W-1:0] e_row0 [3]
);
  import mi3_pkg::*;

  logic signed [2*ELEM_W-1:0] pa_r [9];
  logic signed [2*ELEM_W-1:0] pb_r [9];
  logic signed [ELEM_W-1:0]   e1_r [3];
  logic signed [ELEM_W-1:0]   e2_r [3];
  logic signed [COF_W-1:0]    cof_r [9];

  for (genvar i = 0; i < 9; i++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pa_r[i]  <= e_in[COF_IDX[i][0]] * e_in[COF_IDX[i][1]];
        pb_r[i]  <= e_in[COF_IDX[i][2]] * e_in[COF_IDX[i][3]];
        cof_r[i] <= COF_W'(pa_r[i]) - COF_W'(pb_r[i]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        e1_r[k] <= e_in[k];
        e2_r[k] <= e1_r[k];
      end
    end
  end

  assign cof    = cof_r;
  assign e_row0 = e2_r;

endmodule

[design/mi3_det.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// Three stages: row-zero expansion of the determinant from the cofactors.
// ----------------------------------------------------------------------------
module mi3_det (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [mi3_pkg::ELEM_W-1:0] e_row0 [3],
  input  logic signed [mi3_pkg::COF_W-1:0]  cof_row [3],
  output logic signed [mi3_pkg::DS_W-1:0]   det
);
  import mi3_pkg::*;

  logic signed [2*ELEM_W:0] lo_r [3];
  logic signed [2*ELEM_W:0] hi_r [3];
  logic signed [DS_W-1:0]   t_r  [3];
  logic signed [DS_W-1:0]   det_r;

  // split each cofactor: unsigned low half, signed high part
  for (genvar k = 0; k < 3; k++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        lo_r[k] <= e_row0[k] * $signed({1'b0, cof_row[k][ELEM_W-1:0]});
        hi_r[k] <= e_row0[k] * $signed(cof_row[k][COF_W-1:ELEM_W]);
        t_r[k]  <= (DS_W'(hi_r[k]) <<< ELEM_W) + DS_W'(lo_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= t_r[0] + t_r[1] + t_r[2];
    end
  end

  assign det = det_r;

endmodule

[design/mi3_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage, clipped result.
// ----------------------------------------------------------------------------
module mi3_div #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mi3_pkg::CMAG_W-1:0]     num_mag,
  input  logic                          neg,
  input  logic [mi3_pkg::MAG_W-1:0]      den,
  output mi3_pkg::mi3_clip_t            res
);
  import mi3_pkg::*;

  localparam int QW = ELEM_W + 1;
  localparam int NW = CMAG_W + 2 * FRAC_BITS;
  localparam int SW = MAG_W + QW;
  localparam int CW = ((NW > SW) ? NW : SW) + 1;

  logic [CW-1:0]    rem_r [0:QW-1];
  logic [MAG_W-1:0] den_r [0:QW-1];
  logic [QW-1:0]    q_r   [0:QW];
  logic             ovf_r [0:QW];
  logic             neg_r [0:QW];
  logic [CW-1:0]    num_ext;

  assign num_ext = CW'(num_mag) << (2 * FRAC_BITS);

  // quotient too wide for QW bits: flag and clip at the end
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_ext;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= num_ext >= (CW'(den) << QW);
      neg_r[0] <= neg;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int B = QW - j;
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(den_r[j-1]) << B;
    assign ge  = rem_r[j-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]   <= q_r[j-1] | (ge ? (QW'(1) << B) : '0);
        ovf_r[j] <= ovf_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (rem_r[j-1] - dsh) : rem_r[j-1];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  assign res = mi3_clip(MAG_W'(q_r[QW]), neg_r[QW], ovf_r[QW]);

endmodule

[design/matrix3x3_inverse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Streaming 3x3 inverse by the adjugate, determinant and singular flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one matrix per beat (nine signed Q elements).
//   out_valid/out_ready carry one result per beat: the nine inverse
//   elements, the determinant, an invertible flag and a saturation flag.
//   cfg_we/cfg_data write the zero tolerance; write it only while idle.
//   Throughput: one beat per cycle while the skid is empty. The quotient
//   pipeline produces one bit per stage over ELEM_W + 1 stages.
//   The whole pipeline moves on one enable; valid bits ride alongside.
//   When the receiver stalls, the held result stays on out_data and one
//   more result drops into a skid register; then in_ready falls and the
//   pipeline holds until the skid drains. Nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits and the skid and
//   sets the tolerance to 1; the block accepts beats right after reset.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mi3_pkg::mi3_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mi3_pkg::mi3_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [mi3_pkg::TOL_W-1:0] cfg_data
);
  import mi3_pkg::*;

  localparam int QW = ELEM_W + 1;
  // stages: products, cofactors, three det stages, abs, divider entry, QW steps
  localparam int PL = 7 + QW;

  logic             en;
  logic [PL-1:0]    v_r;
  logic [TOL_W-1:0] tol_r;

  logic signed [ELEM_W-1:0] e_in   [9];
  logic signed [COF_W-1:0]  cof    [9];
  logic signed [ELEM_W-1:0] e_row0 [3];
  logic signed [COF_W-1:0]  cof_row [3];
  logic signed [DS_W-1:0]   det;

  logic signed [COF_W-1:0]  cofd_r [0:2][9];
  logic [MAG_W-1:0]         dmag_r;
  logic                     dneg_r;
  logic [CMAG_W-1:0]        cmag_r [9];
  logic                     cneg_r [9];
  mi3_clip_t                q      [9];
  mi3_side_t                sb_r   [0:QW];

  mi3_out_t res, out_r, skid_r, out_nxt, skid_nxt;
  logic     ov_r, sv_r, ov_nxt, sv_nxt;

  // the pipeline moves unless the skid is holding a result
  assign en       = !sv_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PL-2:0], in_valid};
    end
  end

  assign e_in[0] = in_data.m00;
  assign e_in[1] = in_data.m01;
  assign e_in[2] = in_data.m02;
  assign e_in[3] = in_data.m10;
  assign e_in[4] = in_data.m11;
  assign e_in[5] = in_data.m12;
  assign e_in[6] = in_data.m20;
  assign e_in[7] = in_data.m21;
  assign e_in[8] = in_data.m22;

  mi3_cof u_cof (
    .clk    (clk),
    .en     (en),
    .e_in   (e_in),
    .cof    (cof),
    .e_row0 (e_row0)
  );

  // row-zero cofactors sit at adjugate column zero
  assign cof_row[0] = cof[0];
  assign cof_row[1] = cof[3];
  assign cof_row[2] = cof[6];

  mi3_det u_det (
    .clk     (clk),
    .en      (en),
    .e_row0  (e_row0),
    .cof_row (cof_row),
    .det     (det)
  );

  // hold the cofactors while the determinant is summed
  always_ff @(posedge clk) begin
    if (en) begin
      cofd_r[0] <= cof;
      cofd_r[1] <= cofd_r[0];
      cofd_r[2] <= cofd_r[1];
    end
  end

  // sign and magnitude of determinant and cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r <= det[DS_W-1];
      dmag_r <= det[DS_W-1] ? MAG_W'(-det) : MAG_W'(det);
      for (int i = 0; i < 9; i++) begin
        cneg_r[i] <= cofd_r[2][i][COF_W-1];
        cmag_r[i] <= cofd_r[2][i][COF_W-1] ? CMAG_W'(-cofd_r[2][i])
                                           : CMAG_W'(cofd_r[2][i]);
      end
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_div
    mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk     (clk),
      .en      (en),
      .num_mag (cmag_r[i]),
      .neg     (cneg_r[i] ^ dneg_r),
      .den     (dmag_r),
      .res     (q[i])
    );
  end

  // determinant, flag and its clip travel beside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0].inv <= dmag_r > (MAG_W'(tol_r) << (2 * FRAC_BITS));
      sb_r[0].det <= mi3_clip(dmag_r >> (2 * FRAC_BITS), dneg_r, 1'b0);
      for (int j = 1; j <= QW; j++) begin
        sb_r[j] <= sb_r[j-1];
      end
    end
  end

  // assemble the result; zero the inverse when singular
  always_comb begin
    logic inv;
    logic qsat;
    inv  = sb_r[QW].inv;
    qsat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      qsat = qsat | q[i].sat;
    end
    res.r00         = inv ? q[0].val : '0;
    res.r01         = inv ? q[1].val : '0;
    res.r02         = inv ? q[2].val : '0;
    res.r10         = inv ? q[3].val : '0;
    res.r11         = inv ? q[4].val : '0;
    res.r12         = inv ? q[5].val : '0;
    res.r20         = inv ? q[6].val : '0;
    res.r21         = inv ? q[7].val : '0;
    res.r22         = inv ? q[8].val : '0;
    res.determinant = sb_r[QW].det.val;
    res.invertible  = inv;
    res.saturated   = sb_r[QW].det.sat | (inv & qsat);
  end

  // output register plus skid
  always_comb begin
    ov_nxt   = ov_r;
    sv_nxt   = sv_r;
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (ov_r && !out_ready) begin
      if (en && v_r[PL-1]) begin
        skid_nxt = res;
        sv_nxt   = 1'b1;
      end
    end else if (sv_r) begin
      out_nxt = skid_r;
      ov_nxt  = 1'b1;
      sv_nxt  = 1'b0;
    end else begin
      out_nxt = res;
      ov_nxt  = v_r[PL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid holds a result while the output register is empty");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_r.invertible) |-> (out_r.r00 == 0 && out_r.r01 == 0 &&
      out_r.r02 == 0 && out_r.r10 == 0 && out_r.r11 == 0 && out_r.r12 == 0 &&
      out_r.r20 == 0 && out_r.r21 == 0 && out_r.r22 == 0))
    else $error("singular result carries a nonzero inverse element");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline valid bits moved while stalled");
`endif

endmodule

[tb/matrix3x3_inverse_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Streams 3x3 matrices through the inverse pipeline under random bursts and
// receiver stalls, predicts determinant, flags and inverse in wide exact
// integer arithmetic, and compares every result beat in order.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_tb;
  import mi3_pkg::*;

  localparam int FB      = FRAC_BITS_DEF;
  localparam int WW      = 256;           // wide exact arithmetic
  localparam int N_RAND  = 2000;
  localparam int LAT     = ELEM_W + 9;
  localparam longint LIMIT = 2000000;

  typedef logic signed [WW-1:0] wide_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  mi3_in_t in_data;
  logic out_valid;
  logic out_ready;
  mi3_out_t out_data;
  logic cfg_we;
  logic [TOL_W-1:0] cfg_data;

  matrix3x3_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  mi3_in_t  pending_mats[$];
  mi3_out_t expected_inv[$];
  logic [TOL_W-1:0] tol_shadow;
  int mismatches;
  int burst_left, gap_left;
  int stall_left, hold_long;
  logic hold_req;
  longint cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clip a sign and magnitude to the element range; flag on clip.
  function automatic logic [ELEM_W-1:0] clip_elem(input wide_t mag, input logic neg,
                                                  inout logic sat);
    wide_t pos_max, neg_max;
    pos_max = (wide_t'(1) <<< (ELEM_W - 1)) - 1;
    neg_max = wide_t'(1) <<< (ELEM_W - 1);
    if (!neg && mag > pos_max) begin
      sat = 1'b1;
      return {1'b0, {(ELEM_W-1){1'b1}}};
    end
    if (neg && mag > neg_max) begin
      sat = 1'b1;
      return {1'b1, {(ELEM_W-1){1'b0}}};
    end
    return neg ? -mag[ELEM_W-1:0] : mag[ELEM_W-1:0];
  endfunction

  // Predict the inverse beat for one matrix at the given tolerance.
  function automatic mi3_out_t predict_inverse(input mi3_in_t m, input logic [TOL_W-1:0] tol);
    wide_t e[9];
    wide_t cof[9];
    wide_t det, dmag, cmag, num, thr;
    logic dneg, cneg, inv, sat;
    logic [ELEM_W-1:0] r[9];
    mi3_out_t o;
    e[0] = m.m00; e[1] = m.m01; e[2] = m.m02;
    e[3] = m.m10; e[4] = m.m11; e[5] = m.m12;
    e[6] = m.m20; e[7] = m.m21; e[8] = m.m22;
    det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
        - e[2]*e[4]*e[6] - e[0]*e[5]*e[7] - e[1]*e[3]*e[8];
    cof[0] = e[4]*e[8] - e[5]*e[7];
    cof[1] = e[2]*e[7] - e[8]*e[1];
    cof[2] = e[1]*e[5] - e[4]*e[2];
    cof[3] = e[5]*e[6] - e[8]*e[3];
    cof[4] = e[0]*e[8] - e[2]*e[6];
    cof[5] = e[2]*e[3] - e[5]*e[0];
    cof[6] = e[3]*e[7] - e[6]*e[4];
    cof[7] = e[1]*e[6] - e[7]*e[0];
    cof[8] = e[0]*e[4] - e[1]*e[3];
    sat = 1'b0;
    dneg = det < 0;
    dmag = dneg ? -det : det;
    thr = wide_t'(tol) <<< (2 * FB);
    inv = dmag > thr;
    o.determinant = clip_elem(dmag >>> (2 * FB), dneg, sat);
    for (int i = 0; i < 9; i++) begin
      r[i] = '0;
      if (inv) begin
        cneg = cof[i] < 0;
        cmag = cneg ? -cof[i] : cof[i];
        num = cmag <<< (2 * FB);
        r[i] = clip_elem(num / dmag, cneg ^ dneg, sat);
      end
    end
    o.r00 = r[0]; o.r01 = r[1]; o.r02 = r[2];
    o.r10 = r[3]; o.r11 = r[4]; o.r12 = r[5];
    o.r20 = r[6]; o.r21 = r[7]; o.r22 = r[8];
    o.invertible = inv;
    o.saturated = sat;
    return o;
  endfunction

  // Queue one matrix and its expectation at the current tolerance.
  task automatic push_mat(input mi3_in_t m);
    pending_mats.push_back(m);
    expected_inv.push_back(predict_inverse(m, tol_shadow));
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 1) ? {1'b0, {(ELEM_W-1){1'b1}}} : {1'b1, {(ELEM_W-1){1'b0}}};
      2: return ELEM_W'(signed'($urandom_range(0, 8 << FB)) - (4 << FB));
      default: return ELEM_W'(signed'($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  function automatic mi3_in_t rand_mat();
    mi3_in_t m;
    int kind;
    kind = $urandom_range(0, 9);
    kind = kind < 5 ? 2 : (kind < 7 ? 0 : (kind < 8 ? 1 : 3));
    m = {rand_elem(kind), rand_elem(kind), rand_elem(kind), rand_elem(kind),
         rand_elem(kind), rand_elem(kind), rand_elem(kind), rand_elem(kind),
         rand_elem(kind)};
    // sometimes force a singular matrix: copy row 0 into row 1
    if ($urandom_range(0, 9) == 0) begin
      m.m10 = m.m00; m.m11 = m.m01; m.m12 = m.m02;
    end
    return m;
  endfunction

  // Wait for the pipeline to drain, then write the tolerance while idle.
  task automatic set_tolerance(input logic [TOL_W-1:0] tol);
    while (pending_mats.size() != 0 || expected_inv.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= tol;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_shadow = tol;
  endtask

  // Sender: bursts of random length with random gaps; hold payload until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) void'(pending_mats.pop_front());
      if (in_valid && !in_ready) begin
        // hold the beat
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_mats.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_mats[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_long <= 0;
    end else if (hold_req && hold_long == 0) begin
      hold_long <= 300;
      out_ready <= 1'b0;
    end else if (hold_long > 1) begin
      hold_long <= hold_long - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
      if (hold_long == 1) hold_long <= 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 12);
      else if ($urandom_range(0, 1) == 0 && $urandom_range(0, 3) == 0) stall_left <= 1;
    end
  end

  // Monitor: compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_inv.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat %h", out_data);
      end else begin
        if (out_data !== expected_inv[0]) begin
          if (mismatches < 10) begin
            $display("mismatch: exp r %h %h %h %h %h %h %h %h %h det %h inv %b sat %b",
                     expected_inv[0].r00, expected_inv[0].r01, expected_inv[0].r02,
                     expected_inv[0].r10, expected_inv[0].r11, expected_inv[0].r12,
                     expected_inv[0].r20, expected_inv[0].r21, expected_inv[0].r22,
                     expected_inv[0].determinant, expected_inv[0].invertible,
                     expected_inv[0].saturated);
            $display("          got r %h %h %h %h %h %h %h %h %h det %h inv %b sat %b",
                     out_data.r00, out_data.r01, out_data.r02,
                     out_data.r10, out_data.r11, out_data.r12,
                     out_data.r20, out_data.r21, out_data.r22,
                     out_data.determinant, out_data.invertible, out_data.saturated);
          end
          mismatches <= mismatches + 1;
        end
        void'(expected_inv.pop_front());
      end
    end
  end

  // Watchdog: end the run on a cycle limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("matrix3x3_inverse_tb failed");
      $finish;
    end
  end

  initial begin
    mi3_in_t m;
    logic [ELEM_W-1:0] one, mx, mn;
    logic [TOL_W-1:0] tols[4];
    one = ELEM_W'(1) << FB;
    mx = {1'b0, {(ELEM_W-1){1'b1}}};
    mn = {1'b1, {(ELEM_W-1){1'b0}}};
    tols[0] = 16'hFFFF; tols[1] = 16'd0; tols[2] = 16'd200; tols[3] = TOL_RESET;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    cycle_cnt = 0;
    hold_req = 1'b0;
    tol_shadow = TOL_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, zero, extremes, singular, small determinants, tiny values.
    push_mat({one, 32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, 32'd0, one});
    push_mat('0);
    push_mat({9{mx}});
    push_mat({9{mn}});
    push_mat({mx, 32'd0, 32'd0, 32'd0, mx, 32'd0, 32'd0, 32'd0, mx});
    push_mat({mn, 32'd0, 32'd0, 32'd0, mn, 32'd0, 32'd0, 32'd0, mn});
    push_mat({mx, mn, mx, mn, mx, mn, mx, mn, mx});
    push_mat({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
    push_mat({one, 32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, 32'd0, 32'd2});
    push_mat({one, 32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, 32'd0, 32'd1});
    push_mat({one, one, one, one, one, one, one, one, one});
    push_mat({-one, 32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, 32'd0, one});
    push_mat({32'd0, one, 32'd0, one, 32'd0, 32'd0, 32'd0, 32'd0, one});
    push_mat({32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0,
              32'd0, 32'd0, 32'hFFFF_FFFF});
    push_mat({one << 8, 32'd0, 32'd0, 32'd0, one << 8, 32'd0, 32'd0, 32'd0, one << 8});
    push_mat({one >> 4, 32'd0, 32'd0, 32'd0, one >> 4, 32'd0, 32'd0, 32'd0, one >> 4});

    // Random phases at several tolerances, extremes included.
    for (int p = 0; p < 5; p++) begin
      if (p > 0) set_tolerance(tols[p-1]);
      for (int i = 0; i < N_RAND / 5; i++) begin
        m = rand_mat();
        push_mat(m);
        if (i % 50 == 0) @(posedge clk);
      end
      // long receiver hold-off while the sender keeps offering
      if (p == 1) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
    end

    while (pending_mats.size() != 0 || expected_inv.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (mismatches == 0 && expected_inv.size() == 0) begin
      $display("matrix3x3_inverse_tb passed");
    end else begin
      $display("matrix3x3_inverse_tb failed");
    end
    $finish;
  end

endmodule
